[src/dcpb_pkg.sv]
// ============================================================================
// dcpb_pkg
// Shared types and constants of the DMA copy program builder.
// ============================================================================
`default_nettype none

package dcpb_pkg;

	localparam int unsigned DEF_MAX_TRANSFER_BYTES = 4194304;
	localparam int unsigned LEN_W                  = 23;
	localparam int unsigned QUEUE_DEPTH            = 2;

	// instruction bytes
	localparam logic [7:0] OP_MOV    = 8'hBC;
	localparam logic [7:0] REG_SAR   = 8'h00;
	localparam logic [7:0] REG_CCR   = 8'h01;
	localparam logic [7:0] REG_DAR   = 8'h02;
	localparam logic [7:0] OP_LP0    = 8'h20;
	localparam logic [7:0] OP_LP1    = 8'h22;
	localparam logic [7:0] OP_LPEND0 = 8'h38;
	localparam logic [7:0] OP_LPEND1 = 8'h3C;
	localparam logic [7:0] OP_LD     = 8'h04;
	localparam logic [7:0] OP_ST     = 8'h08;
	localparam logic [7:0] OP_WMB    = 8'h13;
	localparam logic [7:0] OP_SEV    = 8'h34;
	localparam logic [7:0] OP_END    = 8'h00;
	localparam logic [7:0] BIG_INNER_M1  = 8'hFF;	// 256 pairs per 16 KiB block
	localparam logic [7:0] JMP_INNER     = 8'h02;
	localparam logic [7:0] JMP_OUTER_BIG = 8'h06;
	localparam logic [7:0] SEV_EVENT     = 8'h00;
	localparam logic [31:0] BEAT_SIZES   = (32'd2 << 15) | (32'd2 << 1);
	localparam logic [3:0]  BURST16_M1   = 4'hF;

	typedef struct packed {
		logic has_burst;	// at least one 64-byte block
		logic big_any;
		logic big_multi;
		logic sm_any;
		logic sm_multi;
		logic rem_any;
	} plan_flags_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] attr;
		logic [7:0]  big_m1;
		logic [7:0]  sm_m1;
		logic [3:0]  rem_m1;
		plan_flags_t flags;
	} plan_t;

	typedef enum logic [3:0] {
		SEG_SAR,
		SEG_DAR,
		SEG_CCR16,
		SEG_LP0_BIG,
		SEG_LP1,
		SEG_LDST_BIG,
		SEG_LPEND1,
		SEG_LPEND0_BIG,
		SEG_LP0_SM,
		SEG_LDST_SM,
		SEG_LPEND0_SM,
		SEG_CCR_REM,
		SEG_LDST_REM,
		SEG_WMB,
		SEG_SEV,
		SEG_END
	} seg_t;

	function automatic logic [31:0] ctrl_word(input logic [3:0] m, input logic [31:0] attr);
		ctrl_word = BEAT_SIZES | ({28'd0, m} << 4) | ({28'd0, m} << 18) | attr;
	endfunction

endpackage

`default_nettype wire

[src/dcpb_req_if.sv]
// ============================================================================
// dcpb_req_if
// Copy request channel: valid/ready plus the request fields.
// ============================================================================
`default_nettype none

interface dcpb_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [22:0] length_bytes;
	logic [31:0] attr_bits;

	modport source(output valid, src_addr, dst_addr, length_bytes, attr_bits, input ready);
	modport sink(input valid, src_addr, dst_addr, length_bytes, attr_bits, output ready);
endinterface

`default_nettype wire

[src/dcpb_prog_if.sv]
// ============================================================================
// dcpb_prog_if
// Program byte channel: valid/ready plus one program byte and its last flag.
// ============================================================================
`default_nettype none

interface dcpb_prog_if;
	logic       valid;
	logic       ready;
	logic [7:0] program_byte;
	logic       last;

	modport source(output valid, program_byte, last, input ready);
	modport sink(input valid, program_byte, last, output ready);
endinterface

`default_nettype wire

[src/dcpb_front.sv]
// ============================================================================
// dcpb_front
// Accepts requests, clamps the length and splits it into block counts.
// ============================================================================
`default_nettype none

module dcpb_front #(
	parameter int unsigned MAX_TRANSFER_BYTES = dcpb_pkg::DEF_MAX_TRANSFER_BYTES
) (
	dcpb_req_if.sink         req,
	input  wire logic        full,
	output logic             push,
	output dcpb_pkg::plan_t  plan
);
	import dcpb_pkg::*;

	localparam logic [LEN_W-1:0] MAX_N = LEN_W'(MAX_TRANSFER_BYTES);

	logic [LEN_W-1:0] n_raw;
	logic [LEN_W-1:0] n;
	logic [8:0]       big;
	logic [7:0]       sm;
	logic [3:0]       rem_words;

	always_comb begin
		n_raw     = {req.length_bytes[LEN_W-1:2], 2'b00};
		n         = (n_raw > MAX_N) ? MAX_N : n_raw;
		big       = n[22:14];
		sm        = n[13:6];
		rem_words = n[5:2];

		plan.src             = req.src_addr;
		plan.dst             = req.dst_addr;
		plan.attr            = req.attr_bits;
		plan.big_m1          = big[7:0] - 8'd1;
		plan.sm_m1           = sm - 8'd1;
		plan.rem_m1          = rem_words - 4'd1;
		plan.flags.has_burst = (n[22:6] != '0);
		plan.flags.big_any   = (big != '0);
		plan.flags.big_multi = (big > 9'd1);
		plan.flags.sm_any    = (sm != '0);
		plan.flags.sm_multi  = (sm > 8'd1);
		plan.flags.rem_any   = (rem_words != '0);
	end

	// zero-length requests are taken and dropped
	assign req.ready = !full;
	assign push      = req.valid && !full && (n != '0);

endmodule

`default_nettype wire

[src/dcpb_queue.sv]
// ============================================================================
// dcpb_queue
// Short FIFO of classified requests between front and back.
// ============================================================================
`default_nettype none

module dcpb_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  dcpb_pkg::plan_t      plan_in,
	output logic                 full,
	input  wire logic            pop,
	output dcpb_pkg::plan_t      plan_out,
	output logic                 empty
);
	import dcpb_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	plan_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign plan_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= plan_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

[src/dcpb_back.sv]
// ============================================================================
// dcpb_back
// Sequencer that walks the program segments and emits one byte per cycle while prog is ready.
// ============================================================================
`default_nettype none

module dcpb_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  dcpb_pkg::plan_t  plan_in,
	input  wire logic        empty,
	output logic             pop,
	dcpb_prog_if.source      prog
);
	import dcpb_pkg::*;

	plan_t      cur_q;
	logic       busy_q;
	seg_t       seg_q;
	seg_t       seg_d;
	logic [2:0] idx_q;
	logic [2:0] idx_d;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       adv;
	logic       emit;
	logic [2:0] seg_last;
	logic       seg_done;
	logic       is_end;
	logic [7:0] byte_d;
	logic [31:0] mov_val;
	logic [7:0]  mov_reg;
	seg_t        after_big;
	seg_t        after_sm;

	assign adv      = !ov_q || prog.ready;
	assign emit     = busy_q && adv;
	assign is_end   = (seg_q == SEG_END);
	assign pop      = adv && !empty && (!busy_q || is_end);
	assign seg_done = (idx_q == seg_last);

	always_comb begin
		after_sm  = cur_q.flags.rem_any ? SEG_CCR_REM : SEG_WMB;
		after_big = cur_q.flags.sm_any
			? (cur_q.flags.sm_multi ? SEG_LP0_SM : SEG_LDST_SM) : after_sm;

		seg_last = 3'd1;
		mov_val  = cur_q.src;
		mov_reg  = REG_SAR;
		byte_d   = OP_END;
		seg_d    = seg_q;

		case (seg_q)
			SEG_SAR: begin
				seg_last = 3'd5;
				seg_d    = SEG_DAR;
			end
			SEG_DAR: begin
				seg_last = 3'd5;
				mov_val  = cur_q.dst;
				mov_reg  = REG_DAR;
				seg_d    = cur_q.flags.has_burst ? SEG_CCR16 : after_sm;
			end
			SEG_CCR16: begin
				seg_last = 3'd5;
				mov_val  = ctrl_word(BURST16_M1, cur_q.attr);
				mov_reg  = REG_CCR;
				seg_d    = cur_q.flags.big_any
					? (cur_q.flags.big_multi ? SEG_LP0_BIG : SEG_LP1) : after_big;
			end
			SEG_LP0_BIG: begin
				byte_d = (idx_q == 3'd0) ? OP_LP0 : cur_q.big_m1;
				seg_d  = SEG_LP1;
			end
			SEG_LP1: begin
				byte_d = (idx_q == 3'd0) ? OP_LP1 : BIG_INNER_M1;
				seg_d  = SEG_LDST_BIG;
			end
			SEG_LDST_BIG: begin
				byte_d = (idx_q == 3'd0) ? OP_LD : OP_ST;
				seg_d  = SEG_LPEND1;
			end
			SEG_LPEND1: begin
				byte_d = (idx_q == 3'd0) ? OP_LPEND1 : JMP_INNER;
				seg_d  = cur_q.flags.big_multi ? SEG_LPEND0_BIG : after_big;
			end
			SEG_LPEND0_BIG: begin
				byte_d = (idx_q == 3'd0) ? OP_LPEND0 : JMP_OUTER_BIG;
				seg_d  = after_big;
			end
			SEG_LP0_SM: begin
				byte_d = (idx_q == 3'd0) ? OP_LP0 : cur_q.sm_m1;
				seg_d  = SEG_LDST_SM;
			end
			SEG_LDST_SM: begin
				byte_d = (idx_q == 3'd0) ? OP_LD : OP_ST;
				seg_d  = cur_q.flags.sm_multi ? SEG_LPEND0_SM : after_sm;
			end
			SEG_LPEND0_SM: begin
				byte_d = (idx_q == 3'd0) ? OP_LPEND0 : JMP_INNER;
				seg_d  = after_sm;
			end
			SEG_CCR_REM: begin
				seg_last = 3'd5;
				mov_val  = ctrl_word(cur_q.rem_m1, cur_q.attr);
				mov_reg  = REG_CCR;
				seg_d    = SEG_LDST_REM;
			end
			SEG_LDST_REM: begin
				byte_d = (idx_q == 3'd0) ? OP_LD : OP_ST;
				seg_d  = SEG_WMB;
			end
			SEG_WMB: begin
				seg_last = 3'd0;
				byte_d   = OP_WMB;
				seg_d    = SEG_SEV;
			end
			SEG_SEV: begin
				byte_d = (idx_q == 3'd0) ? OP_SEV : SEV_EVENT;
				seg_d  = SEG_END;
			end
			SEG_END: begin
				seg_last = 3'd0;
				byte_d   = OP_END;
				seg_d    = SEG_SAR;
			end
			default: begin
				seg_d = SEG_SAR;
			end
		endcase

		// register moves share one byte layout
		if (seg_q == SEG_SAR || seg_q == SEG_DAR || seg_q == SEG_CCR16 ||
		    seg_q == SEG_CCR_REM) begin
			case (idx_q)
				3'd0:    byte_d = OP_MOV;
				3'd1:    byte_d = mov_reg;
				3'd2:    byte_d = mov_val[7:0];
				3'd3:    byte_d = mov_val[15:8];
				3'd4:    byte_d = mov_val[23:16];
				default: byte_d = mov_val[31:24];
			endcase
		end

		idx_d = seg_done ? 3'd0 : idx_q + 3'd1;
		if (!seg_done) begin
			seg_d = seg_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= plan_in;
		end
		if (emit) begin
			byte_q <= byte_d;
			last_q <= is_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= SEG_SAR;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				seg_q  <= SEG_SAR;
				idx_q  <= '0;
			end else if (emit) begin
				seg_q <= seg_d;
				idx_q <= idx_d;
				if (is_end) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				ov_q <= emit;
			end
		end
	end

	assign prog.valid        = ov_q;
	assign prog.program_byte = byte_q;
	assign prog.last         = last_q;

endmodule

`default_nettype wire

[src/dma_copy_program_builder.sv]
// ============================================================================
// dma_copy_program_builder
// Turns one memory copy request into the packed byte program of a DMA channel.
// ============================================================================
// Each transfer on req is one copy request; its program leaves on prog, one
// byte per transfer, in execution order: SAR and DAR moves, a 16-beat control
// word with a loop over 16 KiB blocks and a loop over 64-byte blocks when the
// length reaches 64 bytes, a short burst for the 4..60 byte tail, then write
// barrier, send-event 0 and END, with last set on the END byte only. Loops
// that would run once are emitted as a bare body. The length loses its low two
// bits and is clamped to MAX_TRANSFER_BYTES; a request that ends up at zero is
// taken and yields no bytes. A program is 24 to 46 bytes long and goes out at
// one byte per cycle while prog is ready; the byte sequencer is the only
// stage that sets that rate. The front classifies a request in the cycle it
// arrives and parks it in a two-entry queue, so a new request is taken while
// the previous program is still streaming, and the sequencer pops the next one
// in the same cycle as it emits the END byte. Reset has no effect on the output
// other than clearing any program in flight and any queued request.
`default_nettype none

module dma_copy_program_builder #(
	parameter int unsigned MAX_TRANSFER_BYTES = dcpb_pkg::DEF_MAX_TRANSFER_BYTES
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dcpb_req_if.sink    req,
	dcpb_prog_if.source prog
);
	import dcpb_pkg::*;

	// front -> queue
	logic  push;
	logic  full;
	plan_t plan_in;

	// queue -> back
	logic  pop;
	logic  empty;
	plan_t plan_out;

	dcpb_front #(
		.MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
	) u_front (
		.req  (req),
		.full (full),
		.push (push),
		.plan (plan_in)
	);

	dcpb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.plan_in  (plan_in),
		.full     (full),
		.pop      (pop),
		.plan_out (plan_out),
		.empty    (empty)
	);

	// sequencer plus output register
	dcpb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.plan_in (plan_out),
		.empty   (empty),
		.pop     (pop),
		.prog    (prog)
	);

endmodule

`default_nettype wire

[bench/testbench.sv]
// ============================================================================
// testbench
// Self-checking bench for the DMA copy program builder.
// ============================================================================
// Copy requests are driven on the request channel. The program bytes that
// leave on the program channel are compared, byte and last flag, with a
// program built on the bench side for every accepted request. A short table
// of corner requests runs first. Random requests follow in four handshake
// phases: no gaps, a sparse sender, a slow receiver, and light gaps on both.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// instruction encodings
	localparam logic [7:0] INS_MOV    = 8'hBC;
	localparam logic [7:0] SEL_SAR    = 8'h00;
	localparam logic [7:0] SEL_CCR    = 8'h01;
	localparam logic [7:0] SEL_DAR    = 8'h02;
	localparam logic [7:0] INS_LP0    = 8'h20;
	localparam logic [7:0] INS_LP1    = 8'h22;
	localparam logic [7:0] INS_LPEND0 = 8'h38;
	localparam logic [7:0] INS_LPEND1 = 8'h3C;
	localparam logic [7:0] INS_LD     = 8'h04;
	localparam logic [7:0] INS_ST     = 8'h08;
	localparam logic [7:0] INS_WMB    = 8'h13;
	localparam logic [7:0] INS_SEV    = 8'h34;
	localparam logic [7:0] INS_END    = 8'h00;
	localparam logic [7:0] EVENT_ID        = 8'h00;
	localparam logic [7:0] PAIRS_PER_BLK_M1 = 8'd255;	// 256 ld/st pairs per 16 KiB
	localparam logic [7:0] JUMP_INNER      = 8'd2;
	localparam logic [7:0] JUMP_OUTER      = 8'd6;
	// 32-bit beats on both sides: (2<<15) | (2<<1)
	localparam logic [31:0] BURST_BEAT_BITS = 32'h0001_0004;
	localparam logic [22:0] MAX_BYTES       = 23'd4194304;
	localparam int MAX_PROGRAM_LEN = 46;

	localparam int RANDOM_PER_PHASE = 77;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int DRAIN_CYCLES     = 64;

	// how a table row gets its expected program
	typedef enum logic [1:0] {
		EXP_PREDICT,
		EXP_NONE,
		EXP_MIN_PROGRAM
	} exp_kind_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [22:0] len;
		logic [31:0] attr;
		exp_kind_t   kind;
	} request_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} prog_beat_t;

	// shortest program, for a 4-byte copy with every address and attribute bit zero
	localparam logic [7:0] MIN_PROGRAM [24] = '{
		INS_MOV, SEL_SAR, 8'h00, 8'h00, 8'h00, 8'h00,
		INS_MOV, SEL_DAR, 8'h00, 8'h00, 8'h00, 8'h00,
		INS_MOV, SEL_CCR, 8'h04, 8'h00, 8'h01, 8'h00,
		INS_LD, INS_ST, INS_WMB, INS_SEV, EVENT_ID, INS_END
	};

	localparam int N_DIRECTED = 23;
	localparam request_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{32'h0000_0000, 32'h0000_0000, 23'd0,       32'h0000_0000, EXP_NONE},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 23'd3,       32'hFFFF_FFFF, EXP_NONE},	// low bits only
		'{32'h0000_0000, 32'h0000_0000, 23'd4,       32'h0000_0000, EXP_MIN_PROGRAM},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 23'd4,       32'hFFFF_FFFF, EXP_PREDICT},
		'{32'h1234_5677, 32'h89AB_CDEF, 23'd60,      32'h0000_0000, EXP_PREDICT},	// unaligned
		'{32'h0000_1000, 32'h0000_2000, 23'd63,      32'h0000_0000, EXP_PREDICT},
		'{32'h0000_1000, 32'h0000_2000, 23'd64,      32'h0000_0000, EXP_PREDICT},
		'{32'h0000_1000, 32'h0000_2000, 23'd67,      32'h0000_0000, EXP_PREDICT},
		'{32'h0000_1000, 32'h0000_2000, 23'd128,     32'h0000_0000, EXP_PREDICT},
		'{32'h8000_0000, 32'h4000_0000, 23'd16380,   32'h0000_0000, EXP_PREDICT},
		'{32'h8000_0000, 32'h4000_0000, 23'd16384,   32'h0000_0000, EXP_PREDICT},
		'{32'h8000_0000, 32'h4000_0000, 23'd16388,   32'h0000_00F0, EXP_PREDICT},	// beat bits
		'{32'h8000_0000, 32'h4000_0000, 23'd16448,   32'h0000_0000, EXP_PREDICT},
		'{32'h8000_0000, 32'h4000_0000, 23'd32768,   32'h0000_0000, EXP_PREDICT},
		'{32'hDEAD_BEEC, 32'hCAFE_F00C, 23'd32904,   32'h003C_003C, EXP_PREDICT},
		'{32'hFFFF_FFFC, 32'h0000_0004, 23'd4194300, 32'hFFFF_FFFF, EXP_PREDICT},	// longest
		'{32'h0000_0004, 32'hFFFF_FFFC, 23'd4194300, 32'h0000_0000, EXP_PREDICT},
		'{32'h1000_0000, 32'h2000_0000, 23'd4194304, 32'h0000_0000, EXP_PREDICT},
		'{32'h1000_0000, 32'h2000_0000, 23'd4194308, 32'h0000_0000, EXP_PREDICT},	// clamped
		'{32'h1000_0000, 32'h2000_0000, 23'h7FFFFF,  32'h0000_0000, EXP_PREDICT},	// clamped
		'{32'h1000_0000, 32'h2000_0000, 23'd4194303, 32'h0000_0000, EXP_PREDICT},
		'{32'hFFFF_FFFF, 32'h0000_0000, 23'd1,       32'hFFFF_FFFF, EXP_NONE},
		'{32'hAAAA_AAAA, 32'h5555_5555, 23'd200,     32'h5555_5555, EXP_PREDICT}
	};

	logic clk;
	logic arst_n;

	dcpb_req_if  req_ch();
	dcpb_prog_if prog_ch();

	dma_copy_program_builder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.prog   (prog_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// expected program bytes of every accepted request, oldest first
	prog_beat_t expected_program_q [$];
	prog_beat_t want;

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatch_count;
	int request_count;
	int empty_count;
	int longest_count;
	int byte_count;
	int quiet_cycles;

	// ------------------------------------------------------------------
	// program builder on the bench side
	// ------------------------------------------------------------------
	function automatic void add_byte(input logic [7:0] b, input logic fin = 1'b0);
		expected_program_q.push_back('{data: b, last: fin});
	endfunction

	function automatic void add_move(input logic [7:0] sel, input logic [31:0] word);
		add_byte(INS_MOV);
		add_byte(sel);
		for (int i = 0; i < 4; i++)
			add_byte(word[8*i +: 8]);	// little-endian immediate
	endfunction

	function automatic void add_ctrl(input logic [3:0] beats_m1, input logic [31:0] attr);
		add_move(SEL_CCR, BURST_BEAT_BITS | (32'(beats_m1) << 4) | (32'(beats_m1) << 18) | attr);
	endfunction

	// appends the program of one request, returns its length in bytes
	function automatic int predict_program(input logic [31:0] src, input logic [31:0] dst,
			input logic [22:0] len, input logic [31:0] attr);
		logic [22:0] n;
		logic [22:0] blocks;
		int          start_size;
		start_size = expected_program_q.size();
		n = len & ~23'd3;
		if (n > MAX_BYTES)
			n = MAX_BYTES;
		if (n == 0)
			return 0;
		add_move(SEL_SAR, src);
		add_move(SEL_DAR, dst);
		if (n >= 23'd64) begin
			add_ctrl(4'hF, attr);
			// 16 KiB blocks: inner loop of 256 pairs, outer loop only when > 1
			blocks = n >> 14;
			if (blocks != 0) begin
				if (blocks > 1) begin
					add_byte(INS_LP0);
					add_byte(8'(blocks - 23'd1));
				end
				add_byte(INS_LP1);
				add_byte(PAIRS_PER_BLK_M1);
				add_byte(INS_LD);
				add_byte(INS_ST);
				add_byte(INS_LPEND1);
				add_byte(JUMP_INNER);
				if (blocks > 1) begin
					add_byte(INS_LPEND0);
					add_byte(JUMP_OUTER);
				end
				n = n & 23'h3FFF;
			end
			// 64-byte blocks
			blocks = n >> 6;
			if (blocks != 0) begin
				if (blocks > 1) begin
					add_byte(INS_LP0);
					add_byte(8'(blocks - 23'd1));
				end
				add_byte(INS_LD);
				add_byte(INS_ST);
				if (blocks > 1) begin
					add_byte(INS_LPEND0);
					add_byte(JUMP_INNER);
				end
				n = n & 23'h3F;
			end
		end
		// short tail burst
		if (n >= 23'd4) begin
			add_ctrl(4'((n >> 2) - 23'd1), attr);
			add_byte(INS_LD);
			add_byte(INS_ST);
		end
		add_byte(INS_WMB);
		add_byte(INS_SEV);
		add_byte(EVENT_ID);
		add_byte(INS_END, 1'b1);
		return expected_program_q.size() - start_size;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	// Entered and left just after a falling edge. Idle cycles put junk on
	// the payload to show it is ignored without valid.
	task automatic send_request(input request_row_t row);
		int prog_len;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid        <= 1'b0;
			req_ch.src_addr     <= $urandom;
			req_ch.dst_addr     <= $urandom;
			req_ch.length_bytes <= 23'($urandom);
			req_ch.attr_bits    <= $urandom;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.src_addr     <= row.src;
		req_ch.dst_addr     <= row.dst;
		req_ch.length_bytes <= row.len;
		req_ch.attr_bits    <= row.attr;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		// transfer taken at this edge
		request_count++;
		case (row.kind)
			EXP_NONE: begin
				prog_len = 0;
			end
			EXP_MIN_PROGRAM: begin
				foreach (MIN_PROGRAM[i])
					add_byte(MIN_PROGRAM[i], i == 23);
				prog_len = 24;
			end
			default: begin
				prog_len = predict_program(row.src, row.dst, row.len, row.attr);
			end
		endcase
		if (prog_len == 0)
			empty_count++;
		if (prog_len == MAX_PROGRAM_LEN)
			longest_count++;
		@(negedge clk);
	endtask

	// random request, weighted toward short and loop-boundary lengths
	function automatic request_row_t random_request();
		request_row_t row;
		row.src  = $urandom;
		row.dst  = $urandom;
		row.kind = EXP_PREDICT;
		case ($urandom_range(9))
			0:       row.len = 23'($urandom_range(3));
			1, 2, 3: row.len = 23'($urandom_range(63, 4));
			4, 5:    row.len = 23'($urandom_range(16383, 64));
			6:       row.len = 23'($urandom_range(4194303, 16384));
			7:       row.len = 23'($urandom);	// whole field, clamping included
			default: begin
				// block counts picked directly: up to 256 blocks of 16 KiB and up to 255 of 64 bytes
				row.len = 23'(($urandom_range(256) << 14) | ($urandom_range(255) << 6)
						| ($urandom_range(15) << 2) | $urandom_range(3));
			end
		endcase
		case ($urandom_range(3))
			0, 1:    row.attr = 32'h0;
			2:       row.attr = $urandom;
			default: row.attr = 32'h1 << $urandom_range(31);
		endcase
		return row;
	endfunction

	task automatic run_random_phase(input int idle_pct, input int stall_pct);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (RANDOM_PER_PHASE)
			send_request(random_request());
	endtask

	// ------------------------------------------------------------------
	// program side: back-pressure and checking
	// ------------------------------------------------------------------
	always @(negedge clk)
		prog_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

	always @(posedge clk) begin
		if (arst_n && prog_ch.valid === 1'b1 && prog_ch.ready === 1'b1) begin
			byte_count++;
			if (expected_program_q.size() == 0) begin
				$error("program_byte %02h arrived with no program pending",
						prog_ch.program_byte);
				mismatch_count++;
			end else begin
				want = expected_program_q.pop_front();
				if (prog_ch.program_byte !== want.data) begin
					$error("program_byte: expected %02h, actual %02h",
							want.data, prog_ch.program_byte);
					mismatch_count++;
				end
				if (prog_ch.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, prog_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
					|| (prog_ch.valid === 1'b1 && prog_ch.ready === 1'b1))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.src_addr     = '0;
		req_ch.dst_addr     = '0;
		req_ch.length_bytes = '0;
		req_ch.attr_bits    = '0;
		prog_ch.ready       = 1'b0;
		sender_idle_pct     = 0;
		receiver_stall_pct  = 0;
		mismatch_count      = 0;
		request_count       = 0;
		empty_count         = 0;
		longest_count       = 0;
		byte_count          = 0;
		quiet_cycles        = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner table, full rate on both sides
		foreach (DIRECTED_ROWS[i])
			send_request(DIRECTED_ROWS[i]);

		run_random_phase(0, 0);
		run_random_phase(75, 0);
		run_random_phase(0, 75);
		run_random_phase(12, 12);
		req_ch.valid <= 1'b0;

		// let the last programs drain, then watch for stray bytes
		while (expected_program_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d copy requests (%0d empty, %0d of maximum program length),",
				request_count, empty_count, longest_count);
		$display("%0d program bytes checked over four handshake phases, %0d mismatches.",
				byte_count, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
